@@ rtl/psa_pkg.sv @@
// Shared constants, types and helpers for the pixel saturation adjust pipeline.
// Used by every module in rtl/; depends on nothing.
package psa_pkg;

  // Default widths of the top level parameters
  localparam int unsigned CHANNEL_BITS_DEF     = 8;
  localparam int unsigned AMOUNT_FRAC_BITS_DEF = 8;

  // Width of the saturation amount register (signed two's complement)
  localparam int unsigned AMOUNT_BITS = 10;

  // Channels per pixel; index 0 is blue, 1 green, 2 red
  localparam int unsigned NUM_CHAN = 3;

  // Per-pixel status carried from the front end into the coefficient stages
  typedef struct packed {
    logic gray;   // max equals min: pass the pixel through unchanged
    logic boost;  // amount above zero: divide by max(S, 1-p)
  } pix_flags_t;

  // Width of the divisor coefficient: holds delta, dsat, 1-p and 1+p
  function automatic int unsigned coef_bits(int unsigned chan_bits, int unsigned frac_bits);
    return (chan_bits > frac_bits + 1) ? chan_bits : frac_bits + 1;
  endfunction

endpackage

@@ rtl/psa_front.sv @@
// Front end: channel max/min, amount clamp (stage 1), lightness terms (stage 2).
// Depends on psa_pkg.
module psa_front #(
  parameter int unsigned CHANNEL_BITS     = psa_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned AMOUNT_FRAC_BITS = psa_pkg::AMOUNT_FRAC_BITS_DEF
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               in_valid_i,
  output logic                                               in_ready_o,
  input  logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]     chan_i,
  input  logic [psa_pkg::AMOUNT_BITS-1:0]                    amount_i,
  output logic                                               out_valid_o,
  input  logic                                               out_ready_i,
  output logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]     chan_o,
  output psa_pkg::pix_flags_t                                flags_o,
  output logic [CHANNEL_BITS:0]                              sum_o,
  output logic [CHANNEL_BITS-1:0]                            delta_o,
  output logic [CHANNEL_BITS-1:0]                            dsat_o,
  output logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS:0]       d2_o,
  output logic [AMOUNT_FRAC_BITS:0]                          k_o
);

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned F     = AMOUNT_FRAC_BITS;
  localparam int unsigned NC    = psa_pkg::NUM_CHAN;
  localparam int unsigned AW    = (psa_pkg::AMOUNT_BITS > F + 2) ? psa_pkg::AMOUNT_BITS : F + 2;
  localparam int          ONE_Q = 1 << F;

  localparam logic signed [AW-1:0]  AMT_HI = AW'(ONE_Q);
  localparam logic signed [AW-1:0]  AMT_LO = AW'(-ONE_Q);
  localparam logic signed [F+1:0]   ONE_QS = (F+2)'(ONE_Q);
  localparam logic [CB:0]           TWO_M  = {{CB{1'b1}}, 1'b0};

  // Handshake: a stage advances when it is empty or the next one advances
  logic v1_q, v2_q;
  logic en1, en2;

  assign en2         = !v2_q || out_ready_i;
  assign en1         = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  // Stage 1: maximum and minimum channel, clamp the amount to -1.0..+1.0
  logic [NC-1:0][CB-1:0] chan1_q;
  logic [CB-1:0]         mx1_d, mn1_d, mx1_q, mn1_q;
  logic signed [AW-1:0]  amt_ext;
  logic signed [F+1:0]   a1_d, a1_q;

  always_comb begin
    mx1_d = chan_i[0];
    mn1_d = chan_i[0];
    for (int i = 1; i < NC; i++) begin
      if (chan_i[i] > mx1_d) mx1_d = chan_i[i];
      if (chan_i[i] < mn1_d) mn1_d = chan_i[i];
    end
  end

  always_comb begin
    amt_ext = AW'($signed(amount_i));
    if (amt_ext > AMT_HI) begin
      a1_d = ONE_QS;
    end else if (amt_ext < AMT_LO) begin
      a1_d = -ONE_QS;
    end else begin
      a1_d = (F+2)'(amt_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      chan1_q <= chan_i;
      mx1_q   <= mx1_d;
      mn1_q   <= mn1_d;
      a1_q    <= a1_d;
    end
  end

  // Stage 2: sum, delta, saturation denominator, per-channel offsets, gain term
  logic [CB:0]           sum2_d, rest2;
  logic [CB-1:0]         delta2_d, dsat2_d;
  logic [NC-1:0][CB:0]   d2_2_d;
  logic [CB+1:0]         d2_wide;
  logic signed [F+1:0]   k_full;
  logic [F:0]            k2_d;
  psa_pkg::pix_flags_t   flags2_d;

  always_comb begin
    sum2_d   = {1'b0, mx1_q} + {1'b0, mn1_q};
    delta2_d = mx1_q - mn1_q;
    rest2    = TWO_M - sum2_d;
    dsat2_d  = (sum2_d < rest2) ? sum2_d[CB-1:0] : rest2[CB-1:0];
    d2_wide  = '0;
    for (int i = 0; i < NC; i++) begin
      d2_wide   = {1'b0, chan1_q[i], 1'b0} - {1'b0, sum2_d};
      d2_2_d[i] = d2_wide[CB:0];
    end
    flags2_d.gray  = (mx1_q == mn1_q);
    flags2_d.boost = !a1_q[F+1] && (a1_q != '0);
    // 1-p when boosting, 1+p otherwise
    k_full = flags2_d.boost ? (ONE_QS - a1_q) : (ONE_QS + a1_q);
    k2_d   = k_full[F:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      chan_o  <= chan1_q;
      flags_o <= flags2_d;
      sum_o   <= sum2_d;
      delta_o <= delta2_d;
      dsat_o  <= dsat2_d;
      d2_o    <= d2_2_d;
      k_o     <= k2_d;
    end
  end

endmodule

@@ rtl/psa_coef.sv @@
// Coefficient stages 3..6: pick divisor, form per-channel numerator and divisor.
// Depends on psa_pkg.
module psa_coef #(
  parameter int unsigned CHANNEL_BITS     = psa_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned AMOUNT_FRAC_BITS = psa_pkg::AMOUNT_FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]   chan_i,
  input  psa_pkg::pix_flags_t                              flags_i,
  input  logic [CHANNEL_BITS:0]                            sum_i,
  input  logic [CHANNEL_BITS-1:0]                          delta_i,
  input  logic [CHANNEL_BITS-1:0]                          dsat_i,
  input  logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS:0]     d2_i,
  input  logic [AMOUNT_FRAC_BITS:0]                        k_i,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]   chan_o,
  output logic                                             gray_o,
  output logic [psa_pkg::NUM_CHAN-1:0]
               [psa_pkg::coef_bits(CHANNEL_BITS, AMOUNT_FRAC_BITS)+CHANNEL_BITS+2:0] num_o,
  output logic [psa_pkg::coef_bits(CHANNEL_BITS, AMOUNT_FRAC_BITS):0]               den_o
);

  localparam int unsigned CB    = CHANNEL_BITS;
  localparam int unsigned F     = AMOUNT_FRAC_BITS;
  localparam int unsigned NC    = psa_pkg::NUM_CHAN;
  localparam int unsigned CW    = psa_pkg::coef_bits(CB, F);
  localparam int unsigned QW    = F + CB + 1;
  localparam int unsigned SCW   = CW + CB + 1;
  localparam int unsigned DBW   = CW + CB + 2;
  localparam int unsigned NW    = CW + CB + 3;
  localparam int          ONE_Q = 1 << F;

  // Handshake chain over four stages
  logic v3_q, v4_q, v5_q, v6_q;
  logic en3, en4, en5, en6;

  assign en6         = !v6_q || out_ready_i;
  assign en5         = !v5_q || en6;
  assign en4         = !v4_q || en5;
  assign en3         = !v3_q || en4;
  assign in_ready_o  = en3;
  assign out_valid_o = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en3) v3_q <= in_valid_i;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
    end
  end

  // Stage 3: (1-p) * dsat for the divisor choice
  logic [NC-1:0][CB-1:0] chan3_q;
  psa_pkg::pix_flags_t   flags3_q;
  logic [CB:0]           sum3_q;
  logic [CB-1:0]         delta3_q, dsat3_q;
  logic [NC-1:0][CB:0]   d2_3_q;
  logic [F:0]            k3_q;
  logic [QW-1:0]         qd3_d, qd3_q;

  assign qd3_d = QW'(k_i) * QW'(dsat_i);

  always_ff @(posedge clk_i) begin
    if (en3) begin
      chan3_q  <= chan_i;
      flags3_q <= flags_i;
      sum3_q   <= sum_i;
      delta3_q <= delta_i;
      dsat3_q  <= dsat_i;
      d2_3_q   <= d2_i;
      k3_q     <= k_i;
      qd3_q    <= qd3_d;
    end
  end

  // Stage 4: choose divisor C and channel weight B
  logic                  use_s;
  logic [CW-1:0]         c4_d, b4_d, c4_q, b4_q;
  logic [CB:0]           sum1_4_d, sum1_4_q;
  logic [NC-1:0][CB-1:0] chan4_q;
  logic                  gray4_q;
  logic [NC-1:0][CB:0]   d2_4_q;

  always_comb begin
    use_s = {1'b0, delta3_q, {F{1'b0}}} >= qd3_q;
    if (!flags3_q.boost) begin
      c4_d = CW'(ONE_Q);
      b4_d = CW'(k3_q);
    end else if (use_s) begin
      c4_d = CW'(delta3_q);
      b4_d = CW'(dsat3_q);
    end else begin
      c4_d = CW'(k3_q);
      b4_d = CW'(ONE_Q);
    end
    // Rounding adds C once: C * (sum + 1)
    sum1_4_d = sum3_q + (CB+1)'(1);
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      chan4_q  <= chan3_q;
      gray4_q  <= flags3_q.gray;
      d2_4_q   <= d2_3_q;
      c4_q     <= c4_d;
      b4_q     <= b4_d;
      sum1_4_q <= sum1_4_d;
    end
  end

  // Stage 5: products
  logic [SCW-1:0]        sc5_d, sc5_q;
  logic signed [DBW-1:0] db5_d [NC];
  logic signed [DBW-1:0] db5_q [NC];
  logic [CW-1:0]         c5_q;
  logic [NC-1:0][CB-1:0] chan5_q;
  logic                  gray5_q;

  always_comb begin
    sc5_d = SCW'(c4_q) * SCW'(sum1_4_q);
    for (int i = 0; i < NC; i++) begin
      db5_d[i] = DBW'($signed(d2_4_q[i])) * DBW'($signed({1'b0, b4_q}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      sc5_q   <= sc5_d;
      db5_q   <= db5_d;
      c5_q    <= c4_q;
      chan5_q <= chan4_q;
      gray5_q <= gray4_q;
    end
  end

  // Stage 6: numerator sum and doubled divisor
  logic [NC-1:0][NW-1:0] num6_d;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      num6_d[i] = NW'($signed(NW'(sc5_q)) + NW'(db5_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      num_o  <= num6_d;
      den_o  <= {c5_q, 1'b0};
      chan_o <= chan5_q;
      gray_o <= gray5_q;
    end
  end

endmodule

@@ rtl/psa_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, three channel lanes,
// with range check up front and final clamp/pass-through select. Uses psa_pkg.
module psa_div #(
  parameter int unsigned CHANNEL_BITS     = psa_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned AMOUNT_FRAC_BITS = psa_pkg::AMOUNT_FRAC_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]   chan_i,
  input  logic                                             gray_i,
  input  logic [psa_pkg::NUM_CHAN-1:0]
               [psa_pkg::coef_bits(CHANNEL_BITS, AMOUNT_FRAC_BITS)+CHANNEL_BITS+2:0] num_i,
  input  logic [psa_pkg::coef_bits(CHANNEL_BITS, AMOUNT_FRAC_BITS):0]               den_i,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output logic [psa_pkg::NUM_CHAN-1:0][CHANNEL_BITS-1:0]   res_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned NC = psa_pkg::NUM_CHAN;
  localparam int unsigned CW = psa_pkg::coef_bits(CB, AMOUNT_FRAC_BITS);
  localparam int unsigned NW = CW + CB + 3;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned RW = CW + CB + 1;
  localparam int unsigned NS = CB + 1;

  // Handshake chain: stage 0 checks range, stages 1..CB each resolve one bit
  logic [NS-1:0] v_q;
  logic [NS:0]   en;

  assign en[NS]      = out_ready_i;
  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NS-1];

  for (genvar s = 0; s < NS; s++) begin : g_hs
    assign en[s] = !v_q[s] || en[s+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_q[s] <= v_q[s-1];
      end
    end
  end

  // Per-stage payload for stages 0..CB-1
  logic [NC-1:0][CB-1:0] chan_q [CB];
  logic                  gray_q [CB];
  logic [NC-1:0][RW-1:0] rem_q  [CB];
  logic [NC-1:0][CB-1:0] quo_q  [CB];
  logic [NC-1:0]         neg_q  [CB];
  logic [NC-1:0]         ovf_q  [CB];
  logic [DW-1:0]         den_q  [CB];

  // Stage 0: flag negative and too-large quotients, seed the remainder
  logic [NC-1:0]         neg0_d, ovf0_d;
  logic [NC-1:0][RW-1:0] rem0_d;
  logic [RW-1:0]         lim0;

  always_comb begin
    lim0 = {den_i, {CB{1'b0}}};
    for (int l = 0; l < NC; l++) begin
      neg0_d[l] = num_i[l][NW-1];
      ovf0_d[l] = !neg0_d[l] && (num_i[l][NW-2:0] >= {1'b0, lim0});
      rem0_d[l] = num_i[l][RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      chan_q[0] <= chan_i;
      gray_q[0] <= gray_i;
      rem_q[0]  <= rem0_d;
      quo_q[0]  <= '0;
      neg_q[0]  <= neg0_d;
      ovf_q[0]  <= ovf0_d;
      den_q[0]  <= den_i;
    end
  end

  // Stages 1..CB: trial subtract of the divisor shifted to the current bit
  for (genvar s = 1; s < NS; s++) begin : g_bit
    localparam int unsigned J = CB - s;

    logic [NC-1:0][CB-1:0] quo_d;
    logic [RW-1:0]         lim;
    logic [NC-1:0]         take;

    always_comb begin
      lim = RW'(den_q[s-1]) << J;
      for (int l = 0; l < NC; l++) begin
        take[l]  = rem_q[s-1][l] >= lim;
        quo_d[l] = quo_q[s-1][l] | (CB'(take[l]) << J);
      end
    end

    if (s < NS - 1) begin : g_mid
      logic [NC-1:0][RW-1:0] rem_d;

      // Reduce the remainder where the bit was taken
      always_comb begin
        for (int l = 0; l < NC; l++) begin
          rem_d[l] = take[l] ? (rem_q[s-1][l] - lim) : rem_q[s-1][l];
        end
      end

      // Advance partial quotient and remainder
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          chan_q[s] <= chan_q[s-1];
          gray_q[s] <= gray_q[s-1];
          rem_q[s]  <= rem_d;
          quo_q[s]  <= quo_d;
          neg_q[s]  <= neg_q[s-1];
          ovf_q[s]  <= ovf_q[s-1];
          den_q[s]  <= den_q[s-1];
        end
      end
    end else begin : g_last
      // Last bit: pick pass-through, zero, full scale or quotient
      logic [NC-1:0][CB-1:0] res_d;

      always_comb begin
        for (int l = 0; l < NC; l++) begin
          if (gray_q[s-1]) begin
            res_d[l] = chan_q[s-1][l];
          end else if (neg_q[s-1][l]) begin
            res_d[l] = '0;
          end else if (ovf_q[s-1][l]) begin
            res_d[l] = '1;
          end else begin
            res_d[l] = quo_d[l];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          res_o <= res_d;
        end
      end
    end
  end

endmodule

@@ rtl/pixel_saturation_adjust_unit.sv @@
// HSL saturation adjust, one BGR pixel per transaction.
// Pipeline: front end, coefficient stages, divider (one quotient bit per stage).
// Throughput: one pixel per cycle while out_ready_i is high.
// Reset: all stage valid bits clear and the saturation amount returns to 0.
// Depends on psa_pkg, psa_front, psa_coef and psa_div.
module pixel_saturation_adjust_unit #(
  parameter int unsigned CHANNEL_BITS     = psa_pkg::CHANNEL_BITS_DEF,
  parameter int unsigned AMOUNT_FRAC_BITS = psa_pkg::AMOUNT_FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [psa_pkg::AMOUNT_BITS-1:0]    saturation_amount_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [CHANNEL_BITS-1:0]            in_blue_i,
  input  logic [CHANNEL_BITS-1:0]            in_green_i,
  input  logic [CHANNEL_BITS-1:0]            in_red_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [CHANNEL_BITS-1:0]            out_blue_o,
  output logic [CHANNEL_BITS-1:0]            out_green_o,
  output logic [CHANNEL_BITS-1:0]            out_red_o
);

  localparam int unsigned CB = CHANNEL_BITS;
  localparam int unsigned F  = AMOUNT_FRAC_BITS;
  localparam int unsigned NC = psa_pkg::NUM_CHAN;
  localparam int unsigned CW = psa_pkg::coef_bits(CB, F);
  localparam int unsigned NW = CW + CB + 3;

  // Saturation amount register
  logic [psa_pkg::AMOUNT_BITS-1:0] amount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amount_q <= '0;
    end else if (cfg_we_i) begin
      amount_q <= saturation_amount_i;
    end
  end

  // Front end
  logic [NC-1:0][CB-1:0] chan_in;
  logic                  fr_valid, fr_ready;
  logic [NC-1:0][CB-1:0] fr_chan;
  psa_pkg::pix_flags_t   fr_flags;
  logic [CB:0]           fr_sum;
  logic [CB-1:0]         fr_delta, fr_dsat;
  logic [NC-1:0][CB:0]   fr_d2;
  logic [F:0]            fr_k;

  assign chan_in = {in_red_i, in_green_i, in_blue_i};

  psa_front #(
    .CHANNEL_BITS     (CB),
    .AMOUNT_FRAC_BITS (F)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .chan_i      (chan_in),
    .amount_i    (amount_q),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .chan_o      (fr_chan),
    .flags_o     (fr_flags),
    .sum_o       (fr_sum),
    .delta_o     (fr_delta),
    .dsat_o      (fr_dsat),
    .d2_o        (fr_d2),
    .k_o         (fr_k)
  );

  // Coefficient stages
  logic                  co_valid, co_ready;
  logic [NC-1:0][CB-1:0] co_chan;
  logic                  co_gray;
  logic [NC-1:0][NW-1:0] co_num;
  logic [CW:0]           co_den;

  psa_coef #(
    .CHANNEL_BITS     (CB),
    .AMOUNT_FRAC_BITS (F)
  ) u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .chan_i      (fr_chan),
    .flags_i     (fr_flags),
    .sum_i       (fr_sum),
    .delta_i     (fr_delta),
    .dsat_i      (fr_dsat),
    .d2_i        (fr_d2),
    .k_i         (fr_k),
    .out_valid_o (co_valid),
    .out_ready_i (co_ready),
    .chan_o      (co_chan),
    .gray_o      (co_gray),
    .num_o       (co_num),
    .den_o       (co_den)
  );

  // Divider and output select
  logic [NC-1:0][CB-1:0] res;

  psa_div #(
    .CHANNEL_BITS     (CB),
    .AMOUNT_FRAC_BITS (F)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (co_valid),
    .in_ready_o  (co_ready),
    .chan_i      (co_chan),
    .gray_i      (co_gray),
    .num_i       (co_num),
    .den_i       (co_den),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign out_blue_o  = res[0];
  assign out_green_o = res[1];
  assign out_red_o   = res[2];

endmodule
